### rtl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared widths, defaults and the command format of the row scanner.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 16;

  localparam int PIX_W      = 6;
  localparam int IN_ROW_W   = 4;
  localparam int IN_COL_W   = 5;
  localparam int ADDR_W     = 4;
  localparam int INTERVAL_W = 8;
  localparam int ROW_IDX_W  = 5;
  localparam int COL_IDX_W  = 6;
  localparam int CMD_DEPTH  = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd7;
  localparam logic [INTERVAL_W-1:0] TICK_MAX       = 8'hFF;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                 refresh;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [PIX_W-1:0]     pair;
    logic [ROW_IDX_W-1:0] next_row;
  } cmd_t;

endpackage

### rtl/hrs_in_if.sv
// ----------------------------------------------------------------------------
// hrs_in_if
// Input channel: timer ticks and framebuffer writes.
// ----------------------------------------------------------------------------
interface hrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [hrs_pkg::IN_ROW_W-1:0]  write_row;
  logic [hrs_pkg::IN_COL_W-1:0]  write_column;
  logic [hrs_pkg::PIX_W-1:0]     pixel_pair;

  modport source (output valid, kind, write_row, write_column, pixel_pair, input ready);
  modport sink   (input valid, kind, write_row, write_column, pixel_pair, output ready);
endinterface

### rtl/hrs_out_if.sv
// ----------------------------------------------------------------------------
// hrs_out_if
// Result channel: one beat per panel column, then a latch beat.
// ----------------------------------------------------------------------------
interface hrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [hrs_pkg::PIX_W-1:0]   color_bits;
  logic                        shift_clock;
  logic                        latch_pulse;
  logic [hrs_pkg::ADDR_W-1:0]  row_address;
  logic                        blank;
  logic                        last;

  modport source (output valid, color_bits, shift_clock, latch_pulse, row_address, blank,
                  last, input ready);
  modport sink   (input valid, color_bits, shift_clock, latch_pulse, row_address, blank,
                  last, output ready);
endinterface

### rtl/hrs_cfg_if.sv
// ----------------------------------------------------------------------------
// hrs_cfg_if
// Configuration write channel for the refresh interval.
// ----------------------------------------------------------------------------
interface hrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hrs_pkg::INTERVAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/hub75_row_scanner_top.sv
// ----------------------------------------------------------------------------
// hub75_row_scanner_top
// Row scan driver for a LED matrix panel with a cleared framebuffer.
//
// in_ch carries timer ticks (kind 0) and pixel writes (kind 1). A write stores
// a colour pair at a row and column; out-of-range writes are dropped. Every
// refresh_interval ticks (cfg_ch, reset 7) the current row is scanned out as
// COLUMNS beats with shift_clock set, then one beat with latch, blank and last
// set that carries the next row address. Row numbers wrap at ROWS.
// Commands pass through a four-entry queue to the scan engine, which streams
// one result beat per cycle when out_ch is not stalled, from a framebuffer
// with a registered read port. After reset the framebuffer is cleared one
// entry a cycle over all 2**(clog2(ROWS) + clog2(COLUMNS)) entries (512 by
// default); in_ch.ready is low until the clear is done. When out_ch stalls,
// the output register holds its beat, the scan pauses, and in_ch keeps
// accepting until the queue fills.
// ----------------------------------------------------------------------------
module hub75_row_scanner_top #(
  parameter int COLUMNS = hrs_pkg::COLUMNS_DEF,
  parameter int ROWS    = hrs_pkg::ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hrs_in_if.sink    in_ch,
  hrs_cfg_if.sink   cfg_ch,
  hrs_out_if.source out_ch
);

  hrs_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, pop, full, empty, clearing;

  hrs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .clearing (clearing),
    .cmd_full (full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  hrs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  hrs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .clearing  (clearing),
    .out_ch    (out_ch)
  );

endmodule

### rtl/hrs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hrs_cmd_fifo
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module hrs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hrs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output hrs_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int DEPTH = hrs_pkg::CMD_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  hrs_pkg::cmd_t  slot_r [DEPTH];
  logic [PW:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW:0]    rd_ptr_r, rd_ptr_nxt;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PW] != rd_ptr_r[PW]) && (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]);
  assign pop_cmd = slot_r[rd_ptr_r[PW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (PW+1)'(push && !full);
    rd_ptr_nxt = rd_ptr_r + (PW+1)'(pop && !empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r[PW-1:0]] <= push_cmd;
    end
  end

endmodule

### rtl/hrs_front.sv
// ----------------------------------------------------------------------------
// hrs_front
// Accepts items, counts ticks and turns them into queued commands.
// ----------------------------------------------------------------------------
module hrs_front #(
  parameter int COLUMNS = hrs_pkg::COLUMNS_DEF,
  parameter int ROWS    = hrs_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hrs_in_if.sink        in_ch,
  hrs_cfg_if.sink       cfg_ch,
  input  logic          clearing,
  input  logic          cmd_full,
  output logic          cmd_push,
  output hrs_pkg::cmd_t cmd
);

  localparam int RW = $clog2(ROWS);

  logic [hrs_pkg::INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [hrs_pkg::INTERVAL_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [RW-1:0]                  row_r, row_nxt, row_next;
  logic                           accept, hit, in_range;

  assign in_ch.ready  = !cmd_full && !clearing;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    tick_inc = (tick_r == hrs_pkg::TICK_MAX) ? tick_r : tick_r + 1'b1;
    hit      = (tick_inc >= interval_r);
    row_next = (row_r == RW'(ROWS - 1)) ? '0 : row_r + 1'b1;
    in_range = (int'(in_ch.write_row) < ROWS) && (int'(in_ch.write_column) < COLUMNS);

    interval_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : interval_r;
    tick_nxt     = tick_r;
    row_nxt      = row_r;
    cmd_push     = 1'b0;
    if (accept && in_ch.kind == hrs_pkg::KIND_TICK) begin
      tick_nxt = hit ? '0 : tick_inc;
      if (hit) begin
        row_nxt  = row_next;
        cmd_push = 1'b1;
      end
    end else if (accept && in_ch.kind == hrs_pkg::KIND_WRITE) begin
      cmd_push = in_range;
    end

    cmd.refresh  = (in_ch.kind == hrs_pkg::KIND_TICK);
    cmd.row      = (in_ch.kind == hrs_pkg::KIND_TICK) ? hrs_pkg::ROW_IDX_W'(row_r)
                                                      : hrs_pkg::ROW_IDX_W'(in_ch.write_row);
    cmd.col      = hrs_pkg::COL_IDX_W'(in_ch.write_column);
    cmd.pair     = in_ch.pixel_pair;
    cmd.next_row = hrs_pkg::ROW_IDX_W'(row_next);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= hrs_pkg::INTERVAL_RESET;
      tick_r     <= '0;
      row_r      <= '0;
    end else begin
      interval_r <= interval_nxt;
      tick_r     <= tick_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

### rtl/hrs_back.sv
// ----------------------------------------------------------------------------
// hrs_back
// Owns the framebuffer: clears it, applies writes and scans rows out.
// ----------------------------------------------------------------------------
module hrs_back #(
  parameter int COLUMNS = hrs_pkg::COLUMNS_DEF,
  parameter int ROWS    = hrs_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hrs_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          clearing,
  hrs_out_if.source     out_ch
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_LATCH = 2'd3;

  logic [hrs_pkg::PIX_W-1:0]     mem [DEPTH];
  logic [hrs_pkg::PIX_W-1:0]     mem_rd_r;

  logic [1:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [hrs_pkg::ROW_IDX_W-1:0] scan_row_r, scan_row_nxt;
  logic [hrs_pkg::ROW_IDX_W-1:0] next_row_r, next_row_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [hrs_pkg::PIX_W-1:0]     color_r;
  logic                          shift_r, latch_r, blank_r, last_r;
  logic [hrs_pkg::ADDR_W-1:0]    addr_r;

  logic                          we, issue, out_free, load_col, load_latch;
  logic [AW-1:0]                 wa, ra;
  logic [hrs_pkg::PIX_W-1:0]     wd;

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_ch.ready;
  assign load_col   = rd_pend_r && out_free;
  assign load_latch = (state_r == ST_LATCH) && !rd_pend_r && out_free;
  assign issue      = (state_r == ST_SCAN) && (!rd_pend_r || load_col);
  assign cmd_pop    = (state_r == ST_IDLE) && !cmd_empty;
  assign ra         = {scan_row_r[RW-1:0], col_r};

  always_comb begin
    we = 1'b0;
    wa = clr_r;
    wd = '0;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (cmd_pop && !cmd.refresh) begin
      we = 1'b1;
      wa = {cmd.row[RW-1:0], cmd.col[CW-1:0]};
      wd = cmd.pair;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    col_nxt      = col_r;
    scan_row_nxt = scan_row_r;
    next_row_nxt = next_row_r;
    rd_pend_nxt  = issue || (rd_pend_r && !load_col);
    out_valid_nxt = (load_col || load_latch) ? 1'b1 : (out_valid_r && !out_ch.ready);
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_pop && cmd.refresh) begin
          scan_row_nxt = cmd.row;
          next_row_nxt = cmd.next_row;
          col_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (col_r == CW'(COLUMNS - 1)) begin
            state_nxt = ST_LATCH;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      ST_LATCH: begin
        if (load_latch) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    scan_row_r <= scan_row_nxt;
    next_row_r <= next_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      mem_rd_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (load_col) begin
      color_r <= mem_rd_r;
      shift_r <= 1'b1;
      latch_r <= 1'b0;
      addr_r  <= scan_row_r[hrs_pkg::ADDR_W-1:0];
      blank_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (load_latch) begin
      color_r <= '0;
      shift_r <= 1'b0;
      latch_r <= 1'b1;
      addr_r  <= next_row_r[hrs_pkg::ADDR_W-1:0];
      blank_r <= 1'b1;
      last_r  <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.color_bits  = color_r;
  assign out_ch.shift_clock = shift_r;
  assign out_ch.latch_pulse = latch_r;
  assign out_ch.row_address = addr_r;
  assign out_ch.blank       = blank_r;
  assign out_ch.last        = last_r;

endmodule

### test/hub75_row_scanner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hub75_row_scanner_top_tb
// Self-checking bench for the LED panel row scanner. A directed table covers
// pixel writes at three framebuffer corners, the first refresh after reset, the
// smallest, zero and largest refresh intervals and a lowered interval with
// ticks pending. Random ticks and writes follow over several intervals and
// idling mixes, with one long result stall. Every result beat is checked
// field by field against a behavioural shadow of the framebuffer and scan.
// ----------------------------------------------------------------------------
module hub75_row_scanner_top_tb;

  localparam int COLUMNS        = hrs_pkg::COLUMNS_DEF;
  localparam int ROWS           = hrs_pkg::ROWS_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = COLUMNS + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 70;
  localparam int NUM_PHASES     = 6;
  localparam int NUM_STEPS      = 24;

  typedef struct packed {
    logic [hrs_pkg::PIX_W-1:0]  color;
    logic                       shift;
    logic                       latch;
    logic [hrs_pkg::ADDR_W-1:0] addr;
    logic                       blank;
    logic                       last;
  } panel_beat_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_op_t;

  typedef struct packed {
    step_op_t                       op;
    logic                           kind;
    logic [hrs_pkg::IN_ROW_W-1:0]   row;
    logic [hrs_pkg::IN_COL_W-1:0]   col;
    logic [hrs_pkg::PIX_W-1:0]      pair;
    logic [hrs_pkg::INTERVAL_W-1:0] interval;
    logic                           chk;
    logic [5:0]                     beats;
    logic [hrs_pkg::PIX_W-1:0]      color0;
    logic [hrs_pkg::ADDR_W-1:0]     next_row;
  } scan_step_t;

  logic clk;
  logic rst_n;

  hrs_in_if  in_if();
  hrs_cfg_if cfg_if();
  hrs_out_if out_if();

  hub75_row_scanner_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  logic [hrs_pkg::PIX_W-1:0]      frame_shadow [ROWS][COLUMNS];
  logic [hrs_pkg::ROW_IDX_W-1:0]  row_shadow;
  logic [hrs_pkg::INTERVAL_W-1:0] ticks_shadow;
  logic [hrs_pkg::INTERVAL_W-1:0] interval_shadow;
  logic [hrs_pkg::PIX_W-1:0]      last_color0;
  logic [hrs_pkg::ADDR_W-1:0]     last_next_row;

  panel_beat_t scan_expect_q[$];

  int mismatches;
  int items_accepted;
  int refreshes;
  int row_wraps;
  int beats_checked;
  int interval_writes;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served;

  logic [hrs_pkg::INTERVAL_W-1:0] phase_interval [NUM_PHASES] =
    '{8'd1, 8'd3, 8'd255, 8'd2, 8'd1, 8'd6};

  scan_step_t directed_steps [NUM_STEPS] = '{
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd0,  5'd0,  6'd63, 8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd15, 5'd31, 6'd42, 8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd0,  5'd31, 6'd21, 8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd1,  5'd0,  6'd1,  8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd2,  5'd0,  6'd21, 8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd15, 5'd31, 6'd63, 8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd33, 6'd63, 4'd1},
    '{STEP_CFG,  hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd1,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd33, 6'd1,  4'd2},
    '{STEP_CFG,  hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd33, 6'd21, 4'd3},
    '{STEP_CFG,  hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd255, 1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_CFG,  hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd2,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd33, 6'd0,  4'd4},
    '{STEP_ITEM, hrs_pkg::KIND_WRITE, 4'd4,  5'd0,  6'd51, 8'd0,   1'b0, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd0,  6'd0,  4'd0},
    '{STEP_ITEM, hrs_pkg::KIND_TICK,  4'd0,  5'd0,  6'd0,  8'd0,   1'b1, 6'd33, 6'd51, 4'd5}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("[%0t] beat %0d: %s got %0d, want %0d", $time, beats_checked, field, got, want);
  endtask

  function automatic int predict_scan(input logic kind,
                                      input logic [hrs_pkg::IN_ROW_W-1:0] r,
                                      input logic [hrs_pkg::IN_COL_W-1:0] c,
                                      input logic [hrs_pkg::PIX_W-1:0] p);
    panel_beat_t bt;
    if (kind == hrs_pkg::KIND_WRITE) begin
      if (int'(r) < ROWS && int'(c) < COLUMNS)
        frame_shadow[r][c] = p;
      return 0;
    end
    if (ticks_shadow != hrs_pkg::TICK_MAX)
      ticks_shadow++;
    if (ticks_shadow < interval_shadow)
      return 0;
    ticks_shadow = '0;
    if (int'(row_shadow) >= ROWS)
      row_shadow = '0;
    for (int col = 0; col < COLUMNS; col++) begin
      bt = '{color: frame_shadow[row_shadow][col], shift: 1'b1, latch: 1'b0,
             addr: row_shadow[hrs_pkg::ADDR_W-1:0], blank: 1'b0, last: 1'b0};
      scan_expect_q.push_back(bt);
    end
    last_color0 = frame_shadow[row_shadow][0];
    row_shadow++;
    if (int'(row_shadow) >= ROWS) begin
      row_shadow = '0;
      row_wraps++;
    end
    bt = '{color: '0, shift: 1'b0, latch: 1'b1, addr: row_shadow[hrs_pkg::ADDR_W-1:0],
           blank: 1'b1, last: 1'b1};
    scan_expect_q.push_back(bt);
    last_next_row = row_shadow[hrs_pkg::ADDR_W-1:0];
    refreshes++;
    return COLUMNS + 1;
  endfunction

  task automatic offer_item(input logic kind, input logic [hrs_pkg::IN_ROW_W-1:0] r,
                            input logic [hrs_pkg::IN_COL_W-1:0] c,
                            input logic [hrs_pkg::PIX_W-1:0] p,
                            output int n_beats);
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.write_row    <= r;
    in_if.write_column <= c;
    in_if.pixel_pair   <= p;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_accepted++;
    n_beats = predict_scan(kind, r, c, p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (scan_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [hrs_pkg::INTERVAL_W-1:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid    <= 1'b0;
    interval_shadow  = v;
    interval_writes++;
  endtask

  task automatic random_items(input int count);
    int  n;
    logic k;
    repeat (count) begin
      k = ($urandom_range(99) < 60) ? hrs_pkg::KIND_TICK : hrs_pkg::KIND_WRITE;
      offer_item(k, hrs_pkg::IN_ROW_W'($urandom_range(15)),
                 hrs_pkg::IN_COL_W'($urandom_range(31)),
                 hrs_pkg::PIX_W'($urandom_range(63)), n);
    end
  endtask

  // result side: check each beat, then pick ready for the next cycle
  initial begin
    int hold_left;
    panel_beat_t want;
    hold_left    = 0;
    hold_served  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        beats_checked++;
        if (scan_expect_q.size() == 0) begin
          report_mismatch("beat with nothing expected", 1, 0);
        end else begin
          want = scan_expect_q.pop_front();
          if (out_if.color_bits !== want.color)
            report_mismatch("color_bits", out_if.color_bits, want.color);
          if (out_if.shift_clock !== want.shift)
            report_mismatch("shift_clock", out_if.shift_clock, want.shift);
          if (out_if.latch_pulse !== want.latch)
            report_mismatch("latch_pulse", out_if.latch_pulse, want.latch);
          if (out_if.row_address !== want.addr)
            report_mismatch("row_address", out_if.row_address, want.addr);
          if (out_if.blank !== want.blank)
            report_mismatch("blank", out_if.blank, want.blank);
          if (out_if.last !== want.last)
            report_mismatch("last", out_if.last, want.last);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("hub75_row_scanner_top test failed");
    $finish;
  end

  initial begin
    scan_step_t st;
    int n;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.kind         = hrs_pkg::KIND_TICK;
    in_if.write_row    = '0;
    in_if.write_column = '0;
    in_if.pixel_pair   = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    mismatches         = 0;
    items_accepted     = 0;
    refreshes          = 0;
    row_wraps          = 0;
    beats_checked      = 0;
    interval_writes    = 0;
    hold_requests      = 0;
    send_idle_pct      = 8;
    recv_idle_pct      = 62;
    row_shadow         = '0;
    ticks_shadow       = '0;
    interval_shadow    = hrs_pkg::INTERVAL_RESET;
    last_color0        = '0;
    last_next_row      = '0;
    foreach (frame_shadow[r, c]) frame_shadow[r][c] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.op == STEP_CFG) begin
        write_interval(st.interval);
      end else begin
        offer_item(st.kind, st.row, st.col, st.pair, n);
        if (st.chk) begin
          if (n != int'(st.beats)) begin
            report_mismatch("refresh beat count", n, st.beats);
          end else if (n > 0) begin
            if (last_color0 !== st.color0)
              report_mismatch("column 0 colour", last_color0, st.color0);
            if (last_next_row !== st.next_row)
              report_mismatch("next row address", last_next_row, st.next_row);
          end
        end
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_interval(phase_interval[ph]);
      if (ph < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 62;
      end else if (ph < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // stall the result side at length while ticks keep coming
      if (ph == 4)
        hold_requests++;
      random_items(PHASE_ITEMS);
    end

    drain_results();
    $display("covered %0d input beats, %0d row refreshes with %0d row wraps",
             items_accepted, refreshes, row_wraps);
    $display("checked %0d result beats over %0d interval writes (0, 1 and 255 included)",
             beats_checked, interval_writes);
    if (mismatches == 0 && scan_expect_q.size() == 0) begin
      $display("hub75_row_scanner_top test passed");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", mismatches, scan_expect_q.size());
      $display("hub75_row_scanner_top test failed");
    end
    $finish;
  end

endmodule
